/* design/sfw_pkg.sv */
// ----------------------------------------------------------------------------
// sfw_pkg: shared types and constants for the stochastic field walk step
// Sequencer states, register indexes and format constants.
// ----------------------------------------------------------------------------
`default_nettype none
package sfw_pkg;

  localparam int FIELD_BITS_DEF = 64;
  localparam int NOISE_BITS_DEF = 32;
  localparam int NOISE_FRAC     = 28;
  localparam int TIME_FRAC      = 24;
  localparam int COUPLING_EXP   = -80;
  localparam int THIRD_EXP      = -65;
  localparam logic [63:0] THIRD_MANT = 64'hAAAA_AAAA_AAAA_AAAA;

  localparam logic [2:0] REG_POWER    = 3'd0;
  localparam logic [2:0] REG_COUPLING = 3'd1;
  localparam logic [2:0] REG_CEILING  = 3'd2;
  localparam logic [2:0] REG_EXIT     = 3'd3;
  localparam logic [2:0] REG_START    = 3'd4;
  localparam logic [2:0] REG_STEPS    = 3'd5;

  localparam logic [3:0]  POWER_RST    = 4'd2;
  localparam logic [63:0] COUPLING_RST = 64'd20536000000000;
  localparam logic [63:0] CEILING_RST  = 64'd4268400000000000000;
  localparam logic [63:0] EXIT_RST     = 64'd24879000000000;
  localparam logic [63:0] START_RST    = 64'd4268400000000000000;
  localparam logic [31:0] STEPS_RST    = 32'd1000000;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RC_INIT,   // load potential = coupling, normalize field operand
    ST_RC_NORM,   // choose the next multiply: phi or 1/3
    ST_RC_MUL,    // multiply by phi (n times)
    ST_RC_THIRD,  // multiply by 1/3
    ST_RC_MWAIT,  // wait on multiplier
    ST_RC_SQRT,   // square root iterations
    ST_RC_DIV,    // 2^63 / s iterations
    ST_RC_DONE,
    ST_STEP_TIME,
    ST_DRIFT,     // drift division iterations
    ST_NOISE,     // H * |noise|
    ST_NOISE_W,
    ST_COMBINE,
    ST_OUT
  } state_t;

  // Multiplier request/response bundle.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } mul_rsp_t;

endpackage
`default_nettype wire

/* design/sfw_mul.sv */
// ----------------------------------------------------------------------------
// sfw_mul: shared 64x64 multiplier
// Four 32x32 partial products, one per cycle, accumulated into 128 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module sfw_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sfw_pkg::mul_req_t req,
  output sfw_pkg::mul_rsp_t      rsp
);
  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r, acc_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [6:0]   sh;

  always_comb begin
    opa = cnt_r[0] ? a_r[63:32] : a_r[31:0];
    opb = cnt_r[1] ? b_r[63:32] : b_r[31:0];
    pp  = {32'd0, opa} * {32'd0, opb};
    // partial product weight: 0, 32, 32, 64
    sh  = {cnt_r[1] & cnt_r[0], cnt_r[1] ^ cnt_r[0], 5'd0};
  end

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + ({64'd0, pp} << sh);
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;
endmodule
`default_nettype wire

/* design/stochastic_field_walk_step.sv */
// ----------------------------------------------------------------------------
// stochastic_field_walk_step: one stochastic field step per input beat
// Sequencer around a shared multiplier plus a shared shift/subtract unit.
// ----------------------------------------------------------------------------
// Each input beat carries one noise sample and yields one result beat. A step
// is worked out by a small sequencer: the potential coupling*phi^n/3 (n the
// power exponent) takes (n+1) passes through the shared 64x64 multiplier, the
// square root 32 and the reciprocal 64 iterations of the shared shift/subtract
// unit, the drift division 2F+4 iterations (92 at F=44). The first step of a
// run recomputes H before the step, a step that exits skips the closing
// recompute, and a zero potential skips the root and reciprocal. in_tready is
// high only while idle; the result sits in an output register and the next
// beat is taken as soon as the result has moved into that register, so a
// stalled receiver blocks the input only once a second result is waiting.
`default_nettype none
module stochastic_field_walk_step #(
  parameter int FIELD_BITS = sfw_pkg::FIELD_BITS_DEF,
  parameter int NOISE_BITS = sfw_pkg::NOISE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [NOISE_BITS-1:0] in_tdata,   // noise_sample
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // field_value, elapsed_time, step_number, exited, run_finished, exit_total
  output logic [((FIELD_BITS + 130 + 7) / 8) * 8 - 1:0] out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [63:0]           cfg_data
);
  localparam int FRAC   = FIELD_BITS - 20;
  localparam int RAW_W  = FIELD_BITS + 64 + 32 + 1 + 1 + 32;
  localparam int OUT_W  = ((RAW_W + 7) / 8) * 8;
  localparam int DTOP   = 2 * FRAC + 3;
  localparam logic [FIELD_BITS-1:0] FMAX = '1;

  // configuration
  logic [3:0]            pow_r;
  logic [63:0]           coup_r;
  logic [FIELD_BITS-1:0] ceil_r, exitl_r, start_r;
  logic [31:0]           steps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow_r   <= sfw_pkg::POWER_RST;
      coup_r  <= sfw_pkg::COUPLING_RST;
      ceil_r  <= sfw_pkg::CEILING_RST[FIELD_BITS-1:0];
      exitl_r <= sfw_pkg::EXIT_RST[FIELD_BITS-1:0];
      start_r <= sfw_pkg::START_RST[FIELD_BITS-1:0];
      steps_r <= sfw_pkg::STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sfw_pkg::REG_POWER:    pow_r   <= cfg_data[3:0];
        sfw_pkg::REG_COUPLING: coup_r  <= cfg_data;
        sfw_pkg::REG_CEILING:  ceil_r  <= cfg_data[FIELD_BITS-1:0];
        sfw_pkg::REG_EXIT:     exitl_r <= cfg_data[FIELD_BITS-1:0];
        sfw_pkg::REG_START:    start_r <= cfg_data[FIELD_BITS-1:0];
        sfw_pkg::REG_STEPS:    steps_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // run state
  sfw_pkg::state_t state_r, state_nxt;
  logic [FIELD_BITS-1:0] field_r, field_nxt;
  logic [63:0] time_r, time_nxt;
  logic [31:0] step_r, step_nxt;
  logic [FIELD_BITS-1:0] hub_r, hub_nxt;
  logic [63:0] inc_r, inc_nxt;
  logic        act_r, act_nxt;
  logic [31:0] exc_r, exc_nxt;
  // working registers
  logic [NOISE_BITS-1:0] noise_r, noise_nxt;
  logic        rc_step_r, rc_step_nxt;   // recompute is the end-of-step one
  logic [63:0] vm_r, vm_nxt;             // potential mantissa
  logic signed [15:0] ve_r, ve_nxt;      // potential exponent
  logic [63:0] pm_r, pm_nxt;             // phi mantissa
  logic signed [15:0] pe_r, pe_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [7:0]  it_r, it_nxt;
  logic [63:0] x_r, x_nxt;               // sqrt value / remainder
  logic [63:0] y_r, y_nxt;               // sqrt result / quotient
  logic [63:0] bit_r, bit_nxt;
  logic        sat_r, sat_nxt;
  logic [63:0] drift_r, drift_nxt;
  logic [63:0] t_r, t_nxt;
  logic [RAW_W-1:0] res_r, res_nxt;
  logic        ov_r, ov_nxt;

  sfw_pkg::mul_req_t mreq;
  sfw_pkg::mul_rsp_t mrsp;

  sfw_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  // noise magnitude
  logic                  neg;
  logic [NOISE_BITS-1:0] mag;
  assign neg = noise_r[NOISE_BITS-1];
  assign mag = neg ? (~noise_r + 1'b1) : noise_r;

  // leading zero count over 64 bits (normalization of fresh operands)
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    logic       hit;
    n = 7'd64;
    hit = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i] && !hit) begin
        n = 7'(63 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // v*2^k saturating at max
  function automatic logic [63:0] shsat(input logic [63:0] v, input logic signed [15:0] k,
                                        input logic [63:0] mx);
    logic [127:0] w;
    logic [63:0]  r;
    r = '0;
    w = '0;
    if (v == 0) r = '0;
    else if (k >= 0) begin
      if (k >= 64) r = mx;
      else begin
        w = {64'd0, v} << k[5:0];
        r = (w[127:64] != 0 || w[63:0] > mx) ? mx : w[63:0];
      end
    end else if (k <= -64) r = '0;
    else begin
      r = v >> (-k);
      r = (r > mx) ? mx : r;
    end
    return r;
  endfunction

  // normalize the 128-bit product of two normalized mantissas
  logic [63:0]        nm;
  logic               nsh;
  assign nsh = !mrsp.p[127];
  assign nm  = nsh ? mrsp.p[126:63] : mrsp.p[127:64];

  // shared shift/subtract step values
  logic [63:0] sq_tb;
  logic        sq_ge;
  logic [63:0] dv_r2;
  logic        dv_c, dv_ge, dv_b;
  logic [63:0] fext;
  assign fext  = {{(64-FIELD_BITS){1'b0}}, field_r};
  assign sq_tb = y_r + bit_r;
  assign sq_ge = x_r >= sq_tb;
  // drift dividend bit: n at bit positions 2F..2F+3
  always_comb begin
    dv_b = 1'b0;
    if (it_r >= 8'(2 * FRAC)) dv_b = pow_r[2'(it_r - 8'(2 * FRAC))];
  end
  assign dv_c  = x_r[63];
  assign dv_r2 = {x_r[62:0], (state_r == sfw_pkg::ST_DRIFT) ? dv_b : 1'b0};
  assign dv_ge = dv_c || dv_r2 >= ((state_r == sfw_pkg::ST_DRIFT) ? fext : y_r);

  // combine
  logic [64:0] pfull, qfull, dfull;
  logic [FIELD_BITS-1:0] nf;
  always_comb begin
    pfull = {1'b0, fext} + (neg ? 65'd0 : {1'b0, t_r});
    qfull = {1'b0, drift_r} + (neg ? {1'b0, t_r} : 65'd0);
    dfull = pfull - qfull;
    if (pfull <= qfull) nf = '0;
    else if (dfull[64] || dfull[63:0] > {{(64-FIELD_BITS){1'b0}}, ceil_r}) nf = ceil_r;
    else nf = dfull[FIELD_BITS-1:0];
  end

  logic signed [15:0] half;
  assign half = ve_r >>> 1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfw_pkg::ST_IDLE:      if (in_tvalid) state_nxt = act_r ? sfw_pkg::ST_STEP_TIME
                                                              : sfw_pkg::ST_RC_INIT;
      sfw_pkg::ST_RC_INIT:   state_nxt = sfw_pkg::ST_RC_NORM;
      sfw_pkg::ST_RC_NORM:   state_nxt = (k_r == pow_r) ? sfw_pkg::ST_RC_THIRD
                                                        : sfw_pkg::ST_RC_MUL;
      sfw_pkg::ST_RC_MUL:    state_nxt = sfw_pkg::ST_RC_MWAIT;
      sfw_pkg::ST_RC_THIRD:  state_nxt = sfw_pkg::ST_RC_MWAIT;
      sfw_pkg::ST_RC_MWAIT:
        if (mrsp.done) begin
          // the 1/3 product lands with k still equal to n
          if (k_r == pow_r) state_nxt = (nm == 0) ? sfw_pkg::ST_RC_DONE
                                                  : sfw_pkg::ST_RC_SQRT;
          else state_nxt = sfw_pkg::ST_RC_NORM;
        end
      sfw_pkg::ST_RC_SQRT:   if (it_r == 8'd31) state_nxt = sfw_pkg::ST_RC_DIV;
      sfw_pkg::ST_RC_DIV:    if (it_r == 8'd63) state_nxt = sfw_pkg::ST_RC_DONE;
      sfw_pkg::ST_RC_DONE:   state_nxt = rc_step_r ? sfw_pkg::ST_OUT : sfw_pkg::ST_STEP_TIME;
      sfw_pkg::ST_STEP_TIME: state_nxt = sfw_pkg::ST_DRIFT;
      sfw_pkg::ST_DRIFT:     if (it_r == 8'd0 || pow_r == 0 || field_r == 0)
                               state_nxt = sfw_pkg::ST_NOISE;
      sfw_pkg::ST_NOISE:     state_nxt = sfw_pkg::ST_NOISE_W;
      sfw_pkg::ST_NOISE_W:   if (mrsp.done) state_nxt = sfw_pkg::ST_COMBINE;
      sfw_pkg::ST_COMBINE:   state_nxt = (nf < exitl_r) ? sfw_pkg::ST_OUT
                                                        : sfw_pkg::ST_RC_INIT;
      sfw_pkg::ST_OUT:       if (!out_tvalid || out_tready) state_nxt = sfw_pkg::ST_IDLE;
      default:               state_nxt = sfw_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    field_nxt = field_r; time_nxt = time_r; step_nxt = step_r; hub_nxt = hub_r;
    inc_nxt = inc_r; act_nxt = act_r; exc_nxt = exc_r; noise_nxt = noise_r;
    rc_step_nxt = rc_step_r; vm_nxt = vm_r; ve_nxt = ve_r; pm_nxt = pm_r; pe_nxt = pe_r;
    k_nxt = k_r; it_nxt = it_r; x_nxt = x_r; y_nxt = y_r; bit_nxt = bit_r;
    sat_nxt = sat_r; drift_nxt = drift_r; t_nxt = t_r; res_nxt = res_r; ov_nxt = ov_r;
    mreq = '0;
    case (state_r)
      sfw_pkg::ST_IDLE: if (in_tvalid) begin
        noise_nxt = in_tdata;
        rc_step_nxt = 1'b0;
        if (!act_r) begin
          field_nxt = start_r;
          time_nxt  = '0;
          step_nxt  = '0;
          act_nxt   = 1'b1;
        end
      end
      sfw_pkg::ST_RC_INIT: begin
        vm_nxt = coup_r << lzc64(coup_r);
        ve_nxt = (coup_r == 0) ? 16'sd0 : 16'(sfw_pkg::COUPLING_EXP - 32'(lzc64(coup_r)));
        pm_nxt = fext << lzc64(fext);
        pe_nxt = (fext == 0) ? 16'sd0 : 16'(-FRAC - 32'(lzc64(fext)));
        k_nxt  = '0;
      end
      sfw_pkg::ST_RC_MUL: begin
        mreq.start = 1'b1; mreq.a = vm_r; mreq.b = pm_r;
        ve_nxt = ve_r + pe_r + 16'sd64;
        ov_nxt = (vm_r == 0 || pm_r == 0);
      end
      sfw_pkg::ST_RC_THIRD: begin
        mreq.start = 1'b1; mreq.a = vm_r; mreq.b = sfw_pkg::THIRD_MANT;
        ve_nxt = ve_r + 16'(sfw_pkg::THIRD_EXP) + 16'sd64;
        ov_nxt = (vm_r == 0);
      end
      sfw_pkg::ST_RC_MWAIT: if (mrsp.done) begin
        k_nxt = k_r + 4'd1;
        if (ov_r) begin
          vm_nxt = '0; ve_nxt = '0;
        end else begin
          vm_nxt = nm;
          ve_nxt = ve_r - (nsh ? 16'sd1 : 16'sd0);
        end
        if (k_r == pow_r) begin
          if (ov_r || nm == 0) begin
            hub_nxt = '0;
            inc_nxt = '1;
          end
          // sqrt setup: odd exponent shifts mantissa right once
          x_nxt   = (ov_r ? 64'd0 : nm) >> ((ve_r - (nsh ? 16'sd1 : 16'sd0)) & 16'sd1);
          ve_nxt  = (ve_r - (nsh ? 16'sd1 : 16'sd0)) +
                    ((ve_r - (nsh ? 16'sd1 : 16'sd0)) & 16'sd1);
          y_nxt   = '0;
          bit_nxt = 64'd1 << 62;
          it_nxt  = '0;
        end
      end
      sfw_pkg::ST_RC_SQRT: begin
        if (sq_ge) begin
          x_nxt = x_r - sq_tb;
          y_nxt = (y_r >> 1) + bit_r;
        end else y_nxt = y_r >> 1;
        bit_nxt = bit_r >> 2;
        it_nxt  = it_r + 8'd1;
        if (it_r == 8'd31) begin
          // s kept in y; start 2^63 / s (dividend bits shifted into x)
          it_nxt = '0;
          x_nxt  = '0;
          bit_nxt = '0;
          hub_nxt = FIELD_BITS'(shsat(sq_ge ? (y_r >> 1) + bit_r : y_r >> 1,
                                      half + 16'(FRAC),
                                      {{(64-FIELD_BITS){1'b0}}, FMAX}));
        end
      end
      sfw_pkg::ST_RC_DIV: begin
        // restoring division 2^63/s, dividend bit 63 first
        x_nxt = {x_r[62:0], (it_r == 8'd0)};
        if ({x_r[62:0], (it_r == 8'd0)} >= y_r) begin
          x_nxt = {x_r[62:0], (it_r == 8'd0)} - y_r;
          bit_nxt = {bit_r[62:0], 1'b1};
        end else bit_nxt = {bit_r[62:0], 1'b0};
        it_nxt = it_r + 8'd1;
        if (it_r == 8'd63)
          inc_nxt = shsat({bit_r[62:0], ({x_r[62:0], 1'b0} >= y_r)},
                          16'(sfw_pkg::TIME_FRAC) - half - 16'sd63, '1);
      end
      sfw_pkg::ST_RC_DONE: begin
        if (rc_step_r) begin
          if ({32'd0, step_r} + 64'd1 >= {32'd0, steps_r}) begin
            res_nxt[FIELD_BITS+64+32+1] = 1'b1;
            act_nxt = 1'b0;
          end else step_nxt = step_r + 32'd1;
        end
      end
      sfw_pkg::ST_STEP_TIME: begin
        time_nxt = (time_r > ~inc_r) ? '1 : time_r + inc_r;
        it_nxt   = 8'(DTOP);
        x_nxt    = '0;
        y_nxt    = '0;
        sat_nxt  = 1'b0;
        drift_nxt = (pow_r == 0) ? 64'd0 : (field_r == 0) ? '1 : 64'd0;
      end
      sfw_pkg::ST_DRIFT: if (pow_r != 0 && field_r != 0) begin
        if (y_r[63]) sat_nxt = 1'b1;
        x_nxt = dv_ge ? dv_r2 - fext : dv_r2;
        y_nxt = {y_r[62:0], dv_ge};
        it_nxt = it_r - 8'd1;
        if (it_r == 8'd0)
          drift_nxt = (sat_r || y_r[63]) ? '1 : {y_r[62:0], dv_ge};
      end
      sfw_pkg::ST_NOISE: begin
        mreq.start = 1'b1;
        mreq.a = {{(64-FIELD_BITS){1'b0}}, hub_r};
        mreq.b = 64'(mag);
      end
      sfw_pkg::ST_NOISE_W: if (mrsp.done)
        t_nxt = (mrsp.p[127:64] >> sfw_pkg::NOISE_FRAC != 0) ? '1
              : 64'(mrsp.p >> sfw_pkg::NOISE_FRAC);
      sfw_pkg::ST_COMBINE: begin
        field_nxt = nf;
        res_nxt = '0;
        res_nxt[FIELD_BITS-1:0] = nf;
        res_nxt[FIELD_BITS +: 64] = time_r;
        res_nxt[FIELD_BITS+64 +: 32] = step_r;
        rc_step_nxt = 1'b1;
        if (nf < exitl_r) begin
          res_nxt[FIELD_BITS+96] = 1'b1;
          res_nxt[FIELD_BITS+97] = 1'b1;
          act_nxt = 1'b0;
          if (exc_r != '1) exc_nxt = exc_r + 32'd1;
        end
      end
      sfw_pkg::ST_OUT: if (!out_tvalid || out_tready)
        res_nxt[FIELD_BITS+98 +: 32] = exc_r;
      default: ;
    endcase
  end

  logic [RAW_W-1:0] obuf_r;
  logic             ov_out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfw_pkg::ST_IDLE;
      act_r <= 1'b0; exc_r <= '0; field_r <= '0; time_r <= '0; step_r <= '0;
      hub_r <= '0; inc_r <= '0; ov_out_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      act_r <= act_nxt; exc_r <= exc_nxt; field_r <= field_nxt; time_r <= time_nxt;
      step_r <= step_nxt; hub_r <= hub_nxt; inc_r <= inc_nxt;
      if (state_r == sfw_pkg::ST_OUT && (!ov_out_r || out_tready)) ov_out_r <= 1'b1;
      else if (out_tready) ov_out_r <= 1'b0;
    end
    noise_r <= noise_nxt; rc_step_r <= rc_step_nxt; vm_r <= vm_nxt; ve_r <= ve_nxt;
    pm_r <= pm_nxt; pe_r <= pe_nxt; k_r <= k_nxt; it_r <= it_nxt; x_r <= x_nxt;
    y_r <= y_nxt; bit_r <= bit_nxt; sat_r <= sat_nxt; drift_r <= drift_nxt;
    t_r <= t_nxt; res_r <= res_nxt; ov_r <= ov_nxt;
    if (state_r == sfw_pkg::ST_OUT && (!ov_out_r || out_tready)) obuf_r <= res_nxt;
  end

  assign in_tready  = (state_r == sfw_pkg::ST_IDLE);
  assign out_tvalid = ov_out_r;
  assign out_tdata  = OUT_W'(obuf_r);
endmodule
`default_nettype wire
